### rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define CPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define CPT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cpt_pkg.sv
// types, constants and helpers of the convex polygon point test
`timescale 1ns / 1ps
package cpt_pkg;

  localparam int MAX_V      = 64;
  localparam int COORD_BITS = 12;
  localparam int MIN_V      = 3;
  localparam int THR_W      = 52;

  localparam int IDXW = $clog2(MAX_V);
  localparam int CNTW = $clog2(MAX_V + 1);
  localparam int EW   = $clog2(MAX_V + 2);

  // arithmetic widths: difference, product, cross, square, sum
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;
  localparam int SW = 2 * CW;
  localparam int NW = SW + 2;

  localparam int IN_TDATA_W  = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((1 + CNTW + 7) / 8) * 8;

  localparam logic [2:0] ST_STORED     = 3'd0;
  localparam logic [2:0] ST_READY      = 3'd1;
  localparam logic [2:0] ST_TOO_FEW    = 3'd2;
  localparam logic [2:0] ST_NOT_CONVEX = 3'd3;
  localparam logic [2:0] ST_TOO_MANY   = 3'd4;
  localparam logic [2:0] ST_TESTED     = 3'd5;
  localparam logic [2:0] ST_NO_POLY    = 3'd6;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] z;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } vtx_t;

  typedef struct packed {
    logic signed [DW-1:0] z;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] x;
  } dvec_t;

  typedef struct packed {
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
  } cvec_t;

  typedef struct packed {
    logic            shift;
    logic            wr_en;
    logic [IDXW-1:0] wr_pos;
    vtx_t            wr_vtx;
  } cell_ctl_t;

  function automatic dvec_t vsub(input vtx_t a, input vtx_t b);
    dvec_t r;
    r.x = DW'(a.x) - DW'(b.x);
    r.y = DW'(a.y) - DW'(b.y);
    r.z = DW'(a.z) - DW'(b.z);
    return r;
  endfunction

endpackage

### rtl/cpt_cell.sv
// one vertex cell of the rotating vertex ring
`timescale 1ns / 1ps
module cpt_cell (
  input  logic                   clk,
  input  cpt_pkg::cell_ctl_t     ctl,
  input  logic [cpt_pkg::IDXW-1:0] cell_id,
  input  cpt_pkg::vtx_t          nb_vtx,
  output cpt_pkg::vtx_t          vtx
);
  import cpt_pkg::*;

  vtx_t vtx_r, vtx_nxt;

  always_comb begin
    vtx_nxt = vtx_r;
    if (ctl.wr_en && (ctl.wr_pos == cell_id)) begin
      vtx_nxt = ctl.wr_vtx;
    end else if (ctl.shift) begin
      vtx_nxt = nb_vtx;
    end
  end

  always_ff @(posedge clk) begin
    vtx_r <= vtx_nxt;
  end

  assign vtx = vtx_r;
endmodule

### rtl/cpt_xunit.sv
// pipelined cross product, squared norm and dot product unit
`timescale 1ns / 1ps
module cpt_xunit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  cpt_pkg::dvec_t               a,
  input  cpt_pkg::dvec_t               b,
  input  cpt_pkg::cvec_t               ref_v,
  output logic                         valid,
  output cpt_pkg::cvec_t               cross_v,
  output logic [cpt_pkg::NW-1:0]       norm,
  output logic signed [cpt_pkg::NW-1:0] dot
);
  import cpt_pkg::*;

  logic signed [PW-1:0] p_r [6];
  cvec_t                cr_r;
  cvec_t                cr2_r;
  cvec_t                cr3_r;
  logic signed [SW-1:0] sq_r [3];
  logic signed [SW-1:0] dp_r [3];
  logic [NW-1:0]        norm_r;
  logic signed [NW-1:0] dot_r;
  logic [3:0]           vld_r, vld_nxt;

  assign vld_nxt = {vld_r[2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: six component products
  always_ff @(posedge clk) begin
    p_r[0] <= PW'(a.y) * PW'(b.z);
    p_r[1] <= PW'(a.z) * PW'(b.y);
    p_r[2] <= PW'(a.z) * PW'(b.x);
    p_r[3] <= PW'(a.x) * PW'(b.z);
    p_r[4] <= PW'(a.x) * PW'(b.y);
    p_r[5] <= PW'(a.y) * PW'(b.x);
  end

  // stage 2: cross components
  always_ff @(posedge clk) begin
    cr_r.x <= CW'(p_r[0]) - CW'(p_r[1]);
    cr_r.y <= CW'(p_r[2]) - CW'(p_r[3]);
    cr_r.z <= CW'(p_r[4]) - CW'(p_r[5]);
  end

  // stage 3: squares and reference products
  always_ff @(posedge clk) begin
    sq_r[0] <= SW'(cr_r.x) * SW'(cr_r.x);
    sq_r[1] <= SW'(cr_r.y) * SW'(cr_r.y);
    sq_r[2] <= SW'(cr_r.z) * SW'(cr_r.z);
    dp_r[0] <= SW'(ref_v.x) * SW'(cr_r.x);
    dp_r[1] <= SW'(ref_v.y) * SW'(cr_r.y);
    dp_r[2] <= SW'(ref_v.z) * SW'(cr_r.z);
    cr2_r   <= cr_r;
  end

  // stage 4: sums, cross carried along to line up with them
  always_ff @(posedge clk) begin
    norm_r <= NW'(sq_r[0]) + NW'(sq_r[1]) + NW'(sq_r[2]);
    dot_r  <= NW'(dp_r[0]) + NW'(dp_r[1]) + NW'(dp_r[2]);
    cr3_r  <= cr2_r;
  end

  assign valid   = vld_r[3];
  assign cross_v = cr3_r;
  assign norm    = norm_r;
  assign dot     = dot_r;
endmodule

### rtl/convex_polygon_point_test.sv
// top level of the convex polygon point test
`timescale 1ns / 1ps
//
//  channel | direction | contents
//  in_     | slave     | tdata {z,y,x} coordinates, tuser op, tlast last vertex
//  out_    | master    | tdata {vertex_count,inside_res}, tuser status
//  cfg_    | slave     | cfg_data collinear threshold, always ready
//
//  vertices live in a ring of MAX_V cells; every walk rotates the ring once
//  a load without last vertex answers from S_FIN once the output is free
//  a query walks the ring, each processed edge waiting for the four-stage
//  cross product unit; a finishing load runs a merge walk, the wrap checks
//  and a convexity walk, with an S_DROP step when the first vertex is dropped
//  reset is synchronous, active low, clears control
//  a waiting result does not stop one new transaction from being taken; the
//  answer to that one holds the block in S_FIN until the output is free
`include "assert_macros.svh"
module convex_polygon_point_test (
  input  logic                              clk,
  input  logic                              rst_n,
  // {pad, coord_z, coord_y, coord_x}
  input  logic [cpt_pkg::IN_TDATA_W-1:0]    in_tdata,
  // op
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // {vertex_count, inside_res}
  output logic [cpt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // status
  output logic [2:0]                        out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [cpt_pkg::THR_W-1:0]         cfg_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready
);
  import cpt_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_WAIT = 4'd2;
  localparam logic [3:0] S_T1   = 4'd3;
  localparam logic [3:0] S_T1W  = 4'd4;
  localparam logic [3:0] S_T2   = 4'd5;
  localparam logic [3:0] S_T2W  = 4'd6;
  localparam logic [3:0] S_DROP = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam logic [1:0] M_MERGE = 2'd0;
  localparam logic [1:0] M_CONV  = 2'd1;
  localparam logic [1:0] M_QUERY = 2'd2;

  // control state
  logic [3:0]      state_r, state_nxt;
  logic [1:0]      mode_r, mode_nxt;
  logic [EW-1:0]   e_r, e_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CNTW-1:0] mcnt_r, mcnt_nxt;
  logic            ready_r, ready_nxt;
  logic            ovf_r, ovf_nxt;
  logic            fail_r, fail_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic            out_valid_r, out_valid_nxt;

  // working registers
  vtx_t  p_r, p_nxt, v0_r, v0_nxt, v1_r, v1_nxt, wa_r, wa_nxt, wb_r, wb_nxt;
  vtx_t  last_r, last_nxt, vcur_r, vcur_nxt;
  vtx_t  mlast_r, mlast_nxt, mprev2_r, mprev2_nxt, m1_r, m1_nxt;
  dvec_t seg_r, seg_nxt, diff_r, diff_nxt;
  cvec_t ref_r, ref_nxt;
  logic [2:0]      res_status_r, res_status_nxt, out_status_r, out_status_nxt;
  logic            res_inside_r, res_inside_nxt, out_inside_r, out_inside_nxt;
  logic [CNTW-1:0] res_count_r, res_count_nxt, out_count_r, out_count_nxt;

  // ring
  vtx_t      cell_vtx [MAX_V];
  vtx_t      head;
  cell_ctl_t cell_ctl;

  // shared arithmetic unit
  logic                 xu_start;
  dvec_t                xu_a, xu_b;
  logic                 xu_valid;
  cvec_t                xu_cross;
  logic [NW-1:0]        xu_norm;
  logic signed [NW-1:0] xu_dot;
  logic                 below;
  logic                 xu_awaited;

  // combinational helpers
  vtx_t            in_vtx;
  logic [EW-1:0]   n_e, n1_e, last_e;
  vtx_t            c_vtx;
  logic [CNTW-1:0] eff_cnt, new_cnt, wr_j, c2;
  logic [EW:0]     pos_full;
  logic            new_ovf, out_free, pass_end;

  genvar g;
  generate
    for (g = 0; g < MAX_V; g++) begin : g_ring
      cpt_cell u_cell (
        .clk    (clk),
        .ctl    (cell_ctl),
        .cell_id(IDXW'(g)),
        .nb_vtx (cell_vtx[(g + 1) % MAX_V]),
        .vtx    (cell_vtx[g])
      );
    end
  endgenerate

  assign head = cell_vtx[0];

  cpt_xunit u_xunit (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (xu_start),
    .a      (xu_a),
    .b      (xu_b),
    .ref_v  (ref_r),
    .valid  (xu_valid),
    .cross_v(xu_cross),
    .norm   (xu_norm),
    .dot    (xu_dot)
  );

  assign below = xu_norm < NW'(thr_r);

  assign in_vtx.x = in_tdata[COORD_BITS-1:0];
  assign in_vtx.y = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_vtx.z = in_tdata[3*COORD_BITS-1:2*COORD_BITS];

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // vertex count of the current walk, its last element slot, and the vertex of the current slot
  always_comb begin
    n_e  = (mode_r == M_CONV) ? EW'(mcnt_r) : EW'(cnt_r);
    n1_e = n_e + EW'(1);
    unique case (mode_r)
      M_CONV:  last_e = (n1_e > EW'(MAX_V - 1)) ? n1_e : EW'(MAX_V - 1);
      M_QUERY: last_e = (n_e > EW'(MAX_V - 1)) ? n_e : EW'(MAX_V - 1);
      default: last_e = EW'(MAX_V - 1);
    endcase
    if (e_r < n_e) begin
      c_vtx = head;
    end else if (e_r == n_e) begin
      c_vtx = v0_r;
    end else begin
      c_vtx = v1_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    e_nxt          = e_r;
    cnt_nxt        = cnt_r;
    mcnt_nxt       = mcnt_r;
    ready_nxt      = ready_r;
    ovf_nxt        = ovf_r;
    fail_nxt       = fail_r;
    thr_nxt        = cfg_valid ? cfg_data : thr_r;
    p_nxt          = p_r;
    v0_nxt         = v0_r;
    v1_nxt         = v1_r;
    wa_nxt         = wa_r;
    wb_nxt         = wb_r;
    last_nxt       = last_r;
    vcur_nxt       = vcur_r;
    mlast_nxt      = mlast_r;
    mprev2_nxt     = mprev2_r;
    m1_nxt         = m1_r;
    seg_nxt        = seg_r;
    diff_nxt       = diff_r;
    ref_nxt        = ref_r;
    res_status_nxt = res_status_r;
    res_inside_nxt = res_inside_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_inside_nxt = out_inside_r;
    out_count_nxt  = out_count_r;
    xu_start       = 1'b0;
    xu_a           = vsub(v0_r, mlast_r);
    xu_b           = vsub(mlast_r, mprev2_r);
    cell_ctl       = '0;
    cell_ctl.wr_vtx = in_vtx;
    eff_cnt        = ready_r ? '0 : cnt_r;
    new_cnt        = eff_cnt;
    new_ovf        = ovf_r;
    wr_j           = mcnt_r;
    pos_full       = '0;
    c2             = mcnt_r;
    pass_end       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_inside_nxt = 1'b0;
          state_nxt      = S_FIN;
          if (in_tuser) begin
            res_count_nxt = cnt_r;
            if (!ready_r) begin
              res_status_nxt = ST_NO_POLY;
            end else begin
              p_nxt     = in_vtx;
              mode_nxt  = M_QUERY;
              e_nxt     = '0;
              fail_nxt  = 1'b0;
              state_nxt = S_RD;
            end
          end else begin
            ready_nxt = 1'b0;
            if (eff_cnt < CNTW'(MAX_V)) begin
              cell_ctl.wr_en  = 1'b1;
              cell_ctl.wr_pos = eff_cnt[IDXW-1:0];
              new_cnt         = eff_cnt + CNTW'(1);
              res_status_nxt  = ST_STORED;
            end else begin
              new_ovf        = 1'b1;
              res_status_nxt = ST_TOO_MANY;
            end
            res_count_nxt = new_cnt;
            cnt_nxt       = new_cnt;
            ovf_nxt       = new_ovf;
            if (in_tlast) begin
              ovf_nxt = 1'b0;
              if (new_ovf) begin
                res_status_nxt = ST_TOO_MANY;
                cnt_nxt        = '0;
              end else if (new_cnt < CNTW'(MIN_V)) begin
                res_status_nxt = ST_TOO_FEW;
                cnt_nxt        = '0;
              end else begin
                mode_nxt  = M_MERGE;
                e_nxt     = '0;
                state_nxt = S_RD;
              end
            end
          end
        end
      end

      // one element slot of a walk: take the head or a saved vertex, rotate, maybe start the unit
      S_RD: begin
        cell_ctl.shift = (e_r < EW'(MAX_V));
        unique case (mode_r)
          M_MERGE: begin
            xu_a = seg_r;
            xu_b = vsub(head, last_r);
            if (e_r == EW'(0)) begin
              v0_nxt = head;
            end
            if (e_r == EW'(1)) begin
              v1_nxt     = head;
              seg_nxt    = vsub(head, v0_r);
              last_nxt   = head;
              mprev2_nxt = v0_r;
              mlast_nxt  = head;
              m1_nxt     = head;
              mcnt_nxt   = CNTW'(2);
            end
            if (e_r >= EW'(2) && e_r < n_e) begin
              xu_start = 1'b1;
              vcur_nxt = head;
              diff_nxt = vsub(head, last_r);
              last_nxt = head;
            end
          end
          M_CONV: begin
            xu_a = vsub(wb_r, wa_r);
            xu_b = vsub(c_vtx, wb_r);
            if (e_r == EW'(0)) begin
              v0_nxt = c_vtx;
            end
            if (e_r == EW'(1)) begin
              v1_nxt = c_vtx;
            end
            wa_nxt   = wb_r;
            wb_nxt   = c_vtx;
            xu_start = (e_r >= EW'(2)) && (e_r <= n1_e);
          end
          default: begin
            xu_a = vsub(c_vtx, wa_r);
            xu_b = vsub(p_r, wa_r);
            if (e_r == EW'(0)) begin
              v0_nxt = c_vtx;
            end
            wa_nxt   = c_vtx;
            xu_start = (e_r >= EW'(1)) && (e_r <= n_e);
          end
        endcase
        if (xu_start) begin
          state_nxt = S_WAIT;
        end else if (e_r == last_e) begin
          pass_end = 1'b1;
        end else begin
          e_nxt = e_r + EW'(1);
        end
      end

      S_WAIT: begin
        if (xu_valid) begin
          unique case (mode_r)
            M_MERGE: begin
              // a collinear vertex replaces the last kept one
              cell_ctl.wr_en  = 1'b1;
              cell_ctl.wr_vtx = vcur_r;
              mlast_nxt       = vcur_r;
              if (below) begin
                wr_j = mcnt_r - CNTW'(1);
                if (mcnt_r == CNTW'(2)) begin
                  m1_nxt = vcur_r;
                end
              end else begin
                wr_j       = mcnt_r;
                seg_nxt    = diff_r;
                mprev2_nxt = mlast_r;
                mcnt_nxt   = mcnt_r + CNTW'(1);
              end
              // index j sits e+1 cells behind the head
              pos_full = (EW+1)'(wr_j) + (EW+1)'(MAX_V - 1) - (EW+1)'(e_r);
              cell_ctl.wr_pos = pos_full[IDXW-1:0];
            end
            M_CONV: begin
              if (e_r == EW'(2)) begin
                ref_nxt = xu_cross;
              end else if (xu_dot[NW-1] || (xu_dot == '0)) begin
                fail_nxt = 1'b1;
              end
            end
            default: begin
              if (e_r == EW'(1)) begin
                ref_nxt = xu_cross;
              end else if (!below && xu_dot[NW-1]) begin
                fail_nxt = 1'b1;
              end
            end
          endcase
          if (e_r == last_e) begin
            pass_end = 1'b1;
          end else begin
            e_nxt     = e_r + EW'(1);
            state_nxt = S_RD;
          end
        end
      end

      // wrap joint at the tail
      S_T1: begin
        if (mcnt_r < CNTW'(MIN_V)) begin
          res_status_nxt = ST_TOO_FEW;
          res_count_nxt  = mcnt_r;
          cnt_nxt        = '0;
          state_nxt      = S_FIN;
        end else begin
          xu_start  = 1'b1;
          state_nxt = S_T1W;
        end
      end

      S_T1W: begin
        if (xu_valid) begin
          c2       = below ? (mcnt_r - CNTW'(1)) : mcnt_r;
          mcnt_nxt = c2;
          if (c2 < CNTW'(MIN_V)) begin
            res_status_nxt = ST_TOO_FEW;
            res_count_nxt  = c2;
            cnt_nxt        = '0;
            state_nxt      = S_FIN;
          end else begin
            state_nxt = S_T2;
          end
        end
      end

      // wrap joint at the head
      S_T2: begin
        xu_b      = vsub(m1_r, v0_r);
        xu_start  = 1'b1;
        state_nxt = S_T2W;
      end

      S_T2W: begin
        if (xu_valid) begin
          if (below) begin
            mcnt_nxt  = mcnt_r - CNTW'(1);
            state_nxt = S_DROP;
          end else begin
            mode_nxt  = M_CONV;
            e_nxt     = '0;
            fail_nxt  = 1'b0;
            state_nxt = S_RD;
          end
        end
      end

      // drop the first vertex: one rotation step renumbers the ring
      S_DROP: begin
        cell_ctl.shift = 1'b1;
        if (mcnt_r < CNTW'(MIN_V)) begin
          res_status_nxt = ST_TOO_FEW;
          res_count_nxt  = mcnt_r;
          cnt_nxt        = '0;
          state_nxt      = S_FIN;
        end else begin
          mode_nxt  = M_CONV;
          e_nxt     = '0;
          fail_nxt  = 1'b0;
          state_nxt = S_RD;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_inside_nxt = res_inside_r;
          out_count_nxt  = res_count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // end of a walk: the ring is back in its home position
    if (pass_end) begin
      e_nxt = '0;
      unique case (mode_r)
        M_MERGE: begin
          state_nxt = S_T1;
        end
        M_CONV: begin
          res_count_nxt = mcnt_r;
          state_nxt     = S_FIN;
          if (fail_nxt) begin
            res_status_nxt = ST_NOT_CONVEX;
            cnt_nxt        = '0;
          end else begin
            res_status_nxt = ST_READY;
            cnt_nxt        = mcnt_r;
            ready_nxt      = 1'b1;
          end
        end
        default: begin
          res_status_nxt = ST_TESTED;
          res_inside_nxt = !fail_nxt;
          res_count_nxt  = cnt_r;
          state_nxt      = S_FIN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_MERGE;
      e_r         <= '0;
      cnt_r       <= '0;
      mcnt_r      <= '0;
      ready_r     <= 1'b0;
      ovf_r       <= 1'b0;
      fail_r      <= 1'b0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      e_r         <= e_nxt;
      cnt_r       <= cnt_nxt;
      mcnt_r      <= mcnt_nxt;
      ready_r     <= ready_nxt;
      ovf_r       <= ovf_nxt;
      fail_r      <= fail_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    v0_r         <= v0_nxt;
    v1_r         <= v1_nxt;
    wa_r         <= wa_nxt;
    wb_r         <= wb_nxt;
    last_r       <= last_nxt;
    vcur_r       <= vcur_nxt;
    mlast_r      <= mlast_nxt;
    mprev2_r     <= mprev2_nxt;
    m1_r         <= m1_nxt;
    seg_r        <= seg_nxt;
    diff_r       <= diff_nxt;
    ref_r        <= ref_nxt;
    res_status_r <= res_status_nxt;
    res_inside_r <= res_inside_nxt;
    res_count_r  <= res_count_nxt;
    out_status_r <= out_status_nxt;
    out_inside_r <= out_inside_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_TDATA_W'({out_count_r, out_inside_r});

  // states in which the sequencer expects a unit result
  assign xu_awaited = (state_r == S_WAIT) || (state_r == S_T1W) || (state_r == S_T2W);

  // a ready polygon always has at least three vertices
  `CPT_ASSERT(a_ready_count, ready_r |-> (cnt_r >= CNTW'(MIN_V)), "ready polygon too small")
  // the store never claims more vertices than cells
  `CPT_ASSERT(a_cnt_range, cnt_r <= CNTW'(MAX_V), "vertex count beyond ring size")
  // unit results only arrive while the sequencer waits for them
  `CPT_ASSERT(a_unit_wait, xu_valid |-> xu_awaited, "unit result not awaited")
endmodule

### bench/convex_polygon_point_test_checker.sv
// checker of the convex polygon point test: predicts every answer and compares it
`timescale 1ns / 1ps
module convex_polygon_point_test_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [cpt_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,
  input  logic                                in_tlast,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [cpt_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic [2:0]                          out_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [cpt_pkg::THR_W-1:0]           cfg_data,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  output int                                  mismatches,
  output int                                  pending
);
  import cpt_pkg::*;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } pt_t;

  typedef struct {
    logic [2:0] status;
    logic       in_poly;
    logic [6:0] count;
  } answer_t;

  // model state of the polygon store
  pt_t        corners[MAX_V];
  int         held;
  bit         poly_ok;
  bit         spilled;
  longint     min_norm;
  answer_t    expected_answers[$];

  function automatic pt_t pdiff(pt_t a, pt_t b);
    pt_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic pt_t pcross(pt_t a, pt_t b);
    pt_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  // cross products stay below 2^27, so every dot product fits in 64 bits
  function automatic longint pdot(pt_t a, pt_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic bit nearly_parallel(pt_t c);
    return pdot(c, c) < min_norm;
  endfunction

  function automatic int merge_runs(int n);
    int  cnt;
    pt_t seg;
    pt_t prev;
    pt_t v;
    cnt  = 2;
    seg  = pdiff(corners[1], corners[0]);
    prev = corners[1];
    for (int i = 2; i < n; i++) begin
      v = corners[i];
      if (nearly_parallel(pcross(seg, pdiff(v, prev)))) begin
        // collinear vertex replaces the last kept one
        corners[cnt-1] = v;
      end else begin
        seg          = pdiff(v, prev);
        corners[cnt] = v;
        cnt++;
      end
      prev = v;
    end
    if (cnt >= 3) begin
      // wrap-around joint, tail then head
      seg = pdiff(corners[0], corners[cnt-1]);
      if (nearly_parallel(pcross(seg, pdiff(corners[cnt-1], corners[cnt-2]))))
        cnt--;
      if (cnt >= 3 && nearly_parallel(pcross(seg, pdiff(corners[1], corners[0])))) begin
        for (int k = 0; k < cnt - 1; k++)
          corners[k] = corners[k+1];
        cnt--;
      end
    end
    return cnt;
  endfunction

  function automatic bit turns_agree(int n);
    pt_t ref_turn;
    pt_t a;
    pt_t b;
    pt_t c;
    ref_turn = pcross(pdiff(corners[1], corners[0]), pdiff(corners[2], corners[1]));
    for (int i = 1; i < n; i++) begin
      a = corners[i];
      b = corners[(i + 1) % n];
      c = corners[(i + 2) % n];
      if (pdot(ref_turn, pcross(pdiff(b, a), pdiff(c, b))) <= 0)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit point_inside(pt_t p, int n);
    pt_t ref_side;
    pt_t side;
    ref_side = pcross(pdiff(corners[1], corners[0]), pdiff(p, corners[0]));
    for (int i = 1; i < n; i++) begin
      side = pcross(pdiff(corners[(i + 1) % n], corners[i]), pdiff(p, corners[i]));
      if (nearly_parallel(side))
        continue;
      if (pdot(ref_side, side) < 0)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // next answer of the block for one accepted input transaction
  function automatic answer_t polygon_step(bit query, bit last, pt_t p);
    answer_t r;
    int      merged;
    r.in_poly = 1'b0;
    if (query) begin
      if (!poly_ok) begin
        r.status = ST_NO_POLY;
      end else begin
        r.status  = ST_TESTED;
        r.in_poly = point_inside(p, held);
      end
      r.count = 7'(held);
      return r;
    end
    if (poly_ok) begin
      poly_ok = 1'b0;
      held    = 0;
    end
    if (held < MAX_V) begin
      corners[held] = p;
      held++;
      r.status = ST_STORED;
    end else begin
      spilled  = 1'b1;
      r.status = ST_TOO_MANY;
    end
    r.count = 7'(held);
    if (last) begin
      if (spilled) begin
        r.status = ST_TOO_MANY;
      end else if (held < MIN_V) begin
        r.status = ST_TOO_FEW;
      end else begin
        merged  = merge_runs(held);
        r.count = 7'(merged);
        if (merged < MIN_V)
          r.status = ST_TOO_FEW;
        else if (!turns_agree(merged))
          r.status = ST_NOT_CONVEX;
        else
          r.status = ST_READY;
      end
      spilled = 1'b0;
      if (r.status == ST_READY) begin
        held    = r.count;
        poly_ok = 1'b1;
      end else begin
        held = 0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pt_t     p;
    answer_t want;
    if (!rst_n) begin
      held       = 0;
      poly_ok    = 1'b0;
      spilled    = 1'b0;
      min_norm   = 0;
      mismatches = 0;
      expected_answers.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        min_norm = longint'(cfg_data);
      if (in_tvalid && in_tready) begin
        p.x = longint'($signed(in_tdata[COORD_BITS-1:0]));
        p.y = longint'($signed(in_tdata[2*COORD_BITS-1:COORD_BITS]));
        p.z = longint'($signed(in_tdata[3*COORD_BITS-1:2*COORD_BITS]));
        expected_answers.push_back(polygon_step(in_tuser, in_tlast, p));
      end
      if (out_tvalid && out_tready) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result transaction status %0d data %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = expected_answers.pop_front();
          if (out_tuser !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          end
          if (out_tdata[0] !== want.in_poly) begin
            mismatches++;
            $display("%0t: inside_res expected %0d actual %0d",
                     $time, want.in_poly, out_tdata[0]);
          end
          if (out_tdata[7:1] !== want.count) begin
            mismatches++;
            $display("%0t: vertex_count expected %0d actual %0d",
                     $time, want.count, out_tdata[7:1]);
          end
        end
      end
    end
    pending = expected_answers.size();
  end

endmodule

### bench/convex_polygon_point_test_tb.sv
// testbench top of the convex polygon point test: stimulus, receiver, watchdog and verdict
`timescale 1ns / 1ps
module convex_polygon_point_test_tb;
  import cpt_pkg::*;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam int   WATCHDOG_LIMIT = 6000;
  localparam int   HOLD_CYCLES    = 400;
  localparam int   DRAIN_CYCLES   = 1000;
  localparam longint THR_MAX      = (64'd1 << THR_W) - 1;

  logic                        clk;
  logic                        rst_n;
  logic [IN_TDATA_W-1:0]       in_tdata;
  logic                        in_tuser;
  logic                        in_tlast;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [OUT_TDATA_W-1:0]      out_tdata;
  logic [2:0]                  out_tuser;
  logic                        out_tvalid;
  logic                        out_tready;
  logic [THR_W-1:0]            cfg_data;
  logic                        cfg_valid;
  logic                        cfg_ready;
  int                          mismatches;
  int                          pending;

  // random gaps on both sides while set
  bit gaps_on;
  // receiver hold-off request, counted down in the receiver process
  bit hold_req;
  int items_sent;
  int quiet_cycles;

  convex_polygon_point_test DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  convex_polygon_point_test_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin : receiver
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (gaps_on) begin
        out_tready <= ($urandom_range(0, 99) >= 31);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int clip(int v);
    if (v > 2047)
      return 2047;
    if (v < -2048)
      return -2048;
    return v;
  endfunction

  // one input transaction; valid stays high from one item to the next unless a random gap drops it
  task automatic push_item(logic op, int x, int y, int z, logic last);
    while (gaps_on && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= last;
    in_tdata  <= {4'b0, 12'(z), 12'(y), 12'(x)};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    items_sent++;
  endtask

  // threshold writes only once every answer is back
  task automatic write_threshold(longint value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= THR_W'(value);
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_query();
    push_item(OP_QUERY, $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
              $urandom_range(0, 4095) - 2048, 1'($urandom));
  endtask

  // roughly circular polygon in a tilted plane, with optional collinear midpoints
  task automatic load_polygon(int n, bit with_mid, int queries);
    int  px[$];
    int  py[$];
    int  pz[$];
    int  cx, cy, cz, r, ta, tb, u, v, k, mx, my, mz;
    real ang0, ang;
    bit  flip;
    cx   = $urandom_range(0, 2000) - 1000;
    cy   = $urandom_range(0, 2000) - 1000;
    cz   = $urandom_range(0, 1000) - 500;
    r    = $urandom_range(4, 900);
    ta   = $urandom_range(0, 2) - 1;
    tb   = $urandom_range(0, 2) - 1;
    flip = $urandom;
    ang0 = $urandom_range(0, 359) * 3.14159265 / 180.0;
    for (int i = 0; i < n; i++) begin
      ang = ang0 + (flip ? -1.0 : 1.0) * 6.2831853 * i / n;
      u   = $rtoi(r * $cos(ang));
      v   = $rtoi(r * $sin(ang));
      px.push_back(clip(cx + u));
      py.push_back(clip(cy + v));
      pz.push_back(clip(cz + (ta * u + tb * v) / 2));
    end
    for (int i = 0; i < n; i++) begin
      push_item(OP_LOAD, px[i], py[i], pz[i], (i == n - 1) && !with_mid);
      if (with_mid && $urandom_range(0, 2) == 0 && i < n - 1) begin
        mx = (px[i] + px[i+1]) / 2;
        my = (py[i] + py[i+1]) / 2;
        mz = (pz[i] + pz[i+1]) / 2;
        push_item(OP_LOAD, mx, my, mz, 1'b0);
      end
    end
    // closing midpoint exercises the wrap-around joint
    if (with_mid)
      push_item(OP_LOAD, (px[n-1] + px[0]) / 2, (py[n-1] + py[0]) / 2,
                (pz[n-1] + pz[0]) / 2, 1'b1);
    for (int q = 0; q < queries; q++) begin
      k = $urandom_range(0, 4);
      if (k == 0)
        random_query();
      else if (k == 1)
        push_item(OP_QUERY, px[q % n], py[q % n], pz[q % n], 1'b0);
      else
        push_item(OP_QUERY, clip(cx + $urandom_range(0, 2 * r + 200) - r - 100),
                  clip(cy + $urandom_range(0, 2 * r + 200) - r - 100), cz, 1'b0);
    end
  endtask

  task automatic random_phase(longint thr, int quota);
    int stop_at, pick, n;
    write_threshold(thr);
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        n = $urandom_range(0, 19) == 0 ? $urandom_range(20, 64) : $urandom_range(3, 10);
        load_polygon(n, $urandom_range(0, 3) == 0, $urandom_range(0, 8));
      end else if (pick < 84) begin
        // broken loads: random points of random length
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          push_item(OP_LOAD, $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                    $urandom_range(0, 4095) - 2048, i == n - 1);
      end else if (pick < 97) begin
        random_query();
      end else begin
        // spilled load: past the store size
        n = MAX_V + $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          push_item(OP_LOAD, $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                    $urandom_range(0, 4095) - 2048, i == n - 1);
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    in_tlast   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    gaps_on    = 1'b1;
    hold_req   = 1'b0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: query before any polygon, then a square with edge queries
    push_item(OP_QUERY, 0, 0, 0, 1'b0);
    push_item(OP_LOAD, 0, 0, 0, 1'b0);
    push_item(OP_LOAD, 100, 0, 0, 1'b0);
    push_item(OP_LOAD, 100, 100, 0, 1'b0);
    push_item(OP_LOAD, 0, 100, 0, 1'b1);
    push_item(OP_QUERY, 50, 50, 0, 1'b1);
    push_item(OP_QUERY, 150, 50, 0, 1'b0);
    push_item(OP_QUERY, -50, 0, 0, 1'b0);   // on the first edge's line
    push_item(OP_QUERY, -2048, -2048, -2048, 1'b0);
    push_item(OP_QUERY, 2047, 2047, 2047, 1'b0);
    // too few vertices
    push_item(OP_LOAD, -2048, 2047, 0, 1'b0);
    push_item(OP_LOAD, 2047, -2048, 0, 1'b1);
    // zero first turn
    push_item(OP_LOAD, 0, 0, 0, 1'b0);
    push_item(OP_LOAD, 10, 0, 0, 1'b0);
    push_item(OP_LOAD, 20, 0, 0, 1'b0);
    push_item(OP_LOAD, 20, 20, 0, 1'b1);
    // not convex
    push_item(OP_LOAD, 0, 0, 0, 1'b0);
    push_item(OP_LOAD, 100, 0, 0, 1'b0);
    push_item(OP_LOAD, 50, 20, 0, 1'b0);
    push_item(OP_LOAD, 50, 100, 0, 1'b1);
    push_item(OP_QUERY, 10, 10, 0, 1'b0);

    // collinear run merged away with a wide threshold
    write_threshold(1000);
    push_item(OP_LOAD, 0, 0, 0, 1'b0);
    push_item(OP_LOAD, 50, 0, 0, 1'b0);
    push_item(OP_LOAD, 100, 0, 0, 1'b0);
    push_item(OP_LOAD, 100, 100, 0, 1'b1);

    // random part: threshold zero with the receiver hold-off
    hold_req = 1'b1;
    random_phase(0, 350);
    // a stretch without random gaps on either side
    gaps_on = 1'b0;
    random_phase($urandom_range(1, 1 << 20), 300);
    gaps_on = 1'b1;
    random_phase(longint'($urandom) << 20, 250);
    random_phase(THR_MAX, 150);
    random_phase($urandom_range(0, 5000), 450);

    in_tvalid <= 1'b0;
    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
